@@ src/clipped_circle_rasterizer_top_macros.svh @@
// assertion macros for the circle rasterizer top level
// used by clipped_circle_rasterizer_top only
`ifndef CLIPPED_CIRCLE_RASTERIZER_TOP_MACROS_SVH
`define CLIPPED_CIRCLE_RASTERIZER_TOP_MACROS_SVH
`define CCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ src/ccr_pkg.sv @@
// shared types and constants for the circle rasterizer
// no dependencies
package ccr_pkg;
    localparam int MAX_DIM_DEF    = 4096;
    localparam int COORD_BITS_DEF = 16;
    localparam int RAD_BITS       = 15;
    localparam int DIM_BITS       = 13;
    localparam int PIX_BITS       = 12;
    localparam int FRAME_RESET    = 4096;
    localparam logic [1:0] CMD_OUTLINE = 2'd0;
    localparam logic [1:0] CMD_FILLED  = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
    localparam logic [3:0] JOB_MARK   = 4'd0;
    localparam logic [3:0] JOB_START  = 4'd1;
    localparam logic [3:0] JOB_SINGLE = 4'd2;
endpackage

@@ src/ccr_if.sv @@
// valid/ready channel carrying a generic payload
// depends on nothing
interface ccr_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/clipped_circle_rasterizer_top.sv @@
// midpoint circle rasterizer with frame clipping. A start command emits the
// axis pixels or the centre span; each advance runs one midpoint iteration
// in the front part and is expanded by the back part at one result per
// cycle while the output is not stalled, one to eight results per item
// (eight mirrored pixels of an outline step at most) as set by the back
// part's output sequencer. A one-entry job register between the parts lets
// the next command start while results drain.
// depends on ccr_pkg, ccr_if, ccr_front, ccr_back and the macro header
`include "clipped_circle_rasterizer_top_macros.svh"
module clipped_circle_rasterizer_top import ccr_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [DIM_BITS-1:0] i_cfg_data,
    ccr_if.sink                 in_ch,
    ccr_if.source               out_ch
);
    localparam int JOB_W = ((COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS + 1) + 2;
    localparam logic [DIM_BITS-1:0] RESET_DIM =
        DIM_BITS'((MAX_DIM < FRAME_RESET) ? MAX_DIM : FRAME_RESET);

    logic [DIM_BITS-1:0] r_width, r_height, clamped;
    assign clamped = (32'(i_cfg_data) > MAX_DIM) ? DIM_BITS'(MAX_DIM) : i_cfg_data;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= RESET_DIM;
            r_height <= RESET_DIM;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WIDTH) r_width <= clamped;
            else r_height <= clamped;
        end
    end

    logic jv, jr, jf, jd, jm;
    logic [3:0] jk;
    logic signed [JOB_W-1:0] jcx, jcy, ja, jb;

    ccr_front #(.CW(COORD_BITS), .JW(JOB_W), .DB(DIM_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_command(in_ch.data.command), .i_center_x(in_ch.data.center_x),
        .i_center_y(in_ch.data.center_y), .i_radius(in_ch.data.radius),
        .i_width(r_width), .i_height(r_height),
        .o_job_valid(jv), .i_job_ready(jr), .o_job_kind(jk), .o_job_fill(jf),
        .o_job_done(jd), .o_job_marker(jm), .o_cx(jcx), .o_cy(jcy), .o_a(ja), .o_b(jb)
    );

    ccr_back #(.JW(JOB_W), .DB(DIM_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(jv), .o_job_ready(jr), .i_job_kind(jk), .i_job_fill(jf),
        .i_job_done(jd), .i_job_marker(jm), .i_cx(jcx), .i_cy(jcy), .i_a(ja), .i_b(jb),
        .i_width(r_width), .i_height(r_height),
        .o_valid(out_ch.valid), .i_ready(out_ch.ready),
        .o_pixel_x(out_ch.data.pixel_x), .o_pixel_y(out_ch.data.pixel_y),
        .o_span_length(out_ch.data.span_length), .o_visible(out_ch.data.visible),
        .o_last(out_ch.data.last), .o_done_res(out_ch.data.done_res)
    );

    `CCR_ASSERT_IMPL(a_done_last, i_clk, i_rst_n,
        out_ch.valid && out_ch.data.done_res, out_ch.data.last)
    `CCR_ASSERT_IMPL(a_invis_zero, i_clk, i_rst_n,
        out_ch.valid && !out_ch.data.visible, out_ch.data.span_length == '0)
    `CCR_ASSERT_NEXT(a_cfg_bound, i_clk, i_rst_n, i_cfg_we,
        32'(r_width) <= MAX_DIM && 32'(r_height) <= MAX_DIM)
endmodule

@@ src/ccr_front.sv @@
// front part: takes commands, runs one midpoint iteration, queues raw items
// depends on ccr_pkg
module ccr_front import ccr_pkg::*; #(
    parameter int CW = COORD_BITS_DEF,
    parameter int JW = COORD_BITS_DEF + 2,
    parameter int DB = DIM_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic signed [CW-1:0] i_center_x,
    input  logic signed [CW-1:0] i_center_y,
    input  logic [RAD_BITS-1:0]  i_radius,
    input  logic [DB-1:0]        i_width,
    input  logic [DB-1:0]        i_height,
    output logic                 o_job_valid,
    input  logic                 i_job_ready,
    output logic [3:0]           o_job_kind,
    output logic                 o_job_fill,
    output logic                 o_job_done,
    output logic                 o_job_marker,
    output logic signed [JW-1:0] o_cx,
    output logic signed [JW-1:0] o_cy,
    output logic signed [JW-1:0] o_a,
    output logic signed [JW-1:0] o_b
);
    localparam int W = JW;
    // job kinds: marker, start, single pixel,
    // advance: optional pair + body, encoded by flags
    logic r_run, r_fill;
    logic signed [W-1:0] r_cx, r_cy, r_dx, r_dy, r_e;
    logic signed [W-1:0] ix, iy, ir, e1, dy1, e2, dx2;
    logic signed [W-1:0] wlim, hlim;
    logic step_ge;
    logic acc;
    assign o_in_ready = !o_job_valid || i_job_ready;
    assign acc = i_in_valid && o_in_ready;
    assign ix = W'(i_center_x);
    assign iy = W'(i_center_y);
    assign ir = W'({1'b0, i_radius});
    assign wlim = W'({1'b0, i_width});
    assign hlim = W'({1'b0, i_height});
    assign e1 = W'(r_e + 2 * r_dy + 1);
    assign dy1 = r_dy + W'(1);
    assign step_ge = e1 >= 0;
    assign e2 = step_ge ? W'(e1 - 2 * r_dx + 1) : e1;
    assign dx2 = step_ge ? r_dx - W'(1) : r_dx;

    logic outside;
    assign outside = (ix + ir < 0) || (iy + ir < 0) ||
        (ix - ir >= wlim) || (iy - ir >= hlim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_fill <= 1'b0;
            r_cx <= '0; r_cy <= '0; r_dx <= '0; r_dy <= '0; r_e <= '0;
            o_job_valid <= 1'b0;
        end else begin
            if (i_job_ready) o_job_valid <= 1'b0;
            if (acc && i_command != CMD_NONE) begin
                o_job_valid <= 1'b1;
                o_job_done <= 1'b0;
                o_job_marker <= 1'b0;
                o_job_kind <= JOB_MARK;
                if (i_command != CMD_ADVANCE) begin
                    r_run <= 1'b0;
                    o_cx <= ix; o_cy <= iy; o_a <= ir; o_b <= '0;
                    o_job_fill <= i_command[0];
                    if (outside) begin
                        o_job_marker <= 1'b1;
                        o_job_done <= 1'b1;
                    end else if (i_radius == '0) begin
                        o_job_kind <= JOB_SINGLE;
                        o_job_done <= 1'b1;
                    end else begin
                        o_job_kind <= JOB_START;
                        r_run <= 1'b1;
                        r_fill <= i_command[0];
                        r_cx <= ix; r_cy <= iy; r_dx <= ir; r_dy <= '0; r_e <= -ir;
                    end
                end else if (!r_run) begin
                    o_job_marker <= 1'b1;
                    o_job_done <= 1'b1;
                end else begin
                    // kind bits: [3] advance, [2] pair, [1] body full, [0] body diag
                    o_job_kind <= {1'b1, step_ge && r_fill, dx2 > dy1, dx2 == dy1};
                    o_job_fill <= r_fill;
                    o_job_done <= !(dx2 > dy1);
                    o_cx <= r_cx; o_cy <= r_cy; o_a <= dx2; o_b <= dy1;
                    r_dx <= dx2; r_dy <= dy1; r_e <= e2;
                    if (!(dx2 > dy1)) r_run <= 1'b0;
                end
            end
        end
    end
endmodule

@@ src/ccr_back.sv @@
// back part: expands one job into clipped pixels or spans, one per cycle while the output is not stalled
// depends on ccr_pkg
module ccr_back import ccr_pkg::*; #(
    parameter int JW = COORD_BITS_DEF + 2,
    parameter int DB = DIM_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    output logic                 o_job_ready,
    input  logic [3:0]           i_job_kind,
    input  logic                 i_job_fill,
    input  logic                 i_job_done,
    input  logic                 i_job_marker,
    input  logic signed [JW-1:0] i_cx,
    input  logic signed [JW-1:0] i_cy,
    input  logic signed [JW-1:0] i_a,
    input  logic signed [JW-1:0] i_b,
    input  logic [DB-1:0]        i_width,
    input  logic [DB-1:0]        i_height,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PIX_BITS-1:0]  o_pixel_x,
    output logic [PIX_BITS-1:0]  o_pixel_y,
    output logic [DIM_BITS-1:0]  o_span_length,
    output logic                 o_visible,
    output logic                 o_last,
    output logic                 o_done_res
);
    localparam int W = JW + 1;
    logic r_busy;
    logic [3:0] r_kind;
    logic r_fill, r_done, r_marker;
    logic signed [W-1:0] r_cx, r_cy, r_a, r_b;
    logic [3:0] r_idx;
    logic [3:0] cnt;
    logic signed [W-1:0] sx, sy, sl;
    logic signed [W-1:0] wlim, hlim;
    logic [3:0] pos;
    logic emit, lastp;

    assign wlim = W'({1'b0, i_width});
    assign hlim = W'({1'b0, i_height});

    // results per job: fill pair first, then body pixels or spans
    always_comb begin
        cnt = 4'd1;
        unique case (1'b1)
            r_marker: cnt = 4'd1;
            r_kind == JOB_START: cnt = r_fill ? 4'd1 : 4'd4;
            r_kind == JOB_SINGLE: cnt = 4'd1;
            default: begin
                cnt = (r_kind[2] ? 4'd2 : 4'd0) +
                      (r_kind[1] ? (r_fill ? 4'd2 : 4'd8) :
                       r_kind[0] ? (r_fill ? 4'd2 : 4'd4) : 4'd0);
                if (cnt == 4'd0) cnt = 4'd1;
            end
        endcase
    end

    always_comb begin
        sx = '0; sy = '0; sl = W'(1); emit = !r_marker; pos = r_idx;
        if (r_kind == JOB_START) begin
            if (r_fill) begin
                sx = r_cx - r_a; sy = r_cy; sl = W'(2 * r_a + 1);
            end else begin
                unique case (r_idx[1:0])
                    2'd0: begin sx = r_cx; sy = r_cy - r_a; end
                    2'd1: begin sx = r_cx - r_a; sy = r_cy; end
                    2'd2: begin sx = r_cx + r_a; sy = r_cy; end
                    default: begin sx = r_cx; sy = r_cy + r_a; end
                endcase
            end
        end else if (r_kind == JOB_SINGLE) begin
            sx = r_cx; sy = r_cy;
        end else if (r_kind[3]) begin
            if (r_kind[2] && r_idx < 4'd2) begin
                // pair rows sit at the column offset before its decrement
                sx = r_cx - r_b + W'(1); sl = W'(2 * r_b - 1);
                sy = r_idx[0] ? r_cy + r_a + W'(1) : r_cy - r_a - W'(1);
            end else begin
                pos = r_kind[2] ? r_idx - 4'd2 : r_idx;
                if (!r_kind[1] && !r_kind[0]) emit = 1'b0;
                if (r_fill) begin
                    sx = r_cx - r_a; sl = W'(2 * r_a + 1);
                    sy = pos[0] ? r_cy + r_b : r_cy - r_b;
                end else begin
                    unique case (pos[2:0])
                        3'd0: begin sx = r_cx - r_a; sy = r_cy - r_b; end
                        3'd1: begin sx = r_cx + r_a; sy = r_cy - r_b; end
                        3'd2: begin sx = r_cx - r_a; sy = r_cy + r_b; end
                        3'd3: begin sx = r_cx + r_a; sy = r_cy + r_b; end
                        3'd4: begin sx = r_cx - r_b; sy = r_cy - r_a; end
                        3'd5: begin sx = r_cx - r_b; sy = r_cy + r_a; end
                        3'd6: begin sx = r_cx + r_b; sy = r_cy - r_a; end
                        default: begin sx = r_cx + r_b; sy = r_cy + r_a; end
                    endcase
                end
            end
        end
    end

    logic signed [W-1:0] x0, x1;
    logic vis;
    always_comb begin
        x0 = sx < 0 ? '0 : sx;
        x1 = sx + sl;
        if (x1 > wlim) x1 = wlim;
        vis = emit && (sy >= 0) && (sy < hlim) && (x1 > x0);
    end

    logic step;
    assign step = r_busy && (!o_valid || i_ready);
    assign lastp = (r_idx == cnt - 4'd1);
    assign o_job_ready = !r_busy || (step && lastp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_valid <= 1'b0;
            r_idx <= '0;
        end else begin
            if (i_ready) o_valid <= 1'b0;
            if (step) begin
                o_valid <= 1'b1;
                o_pixel_x <= vis ? PIX_BITS'(x0) : '0;
                o_pixel_y <= vis ? PIX_BITS'(sy) : '0;
                o_span_length <= vis ? DIM_BITS'(x1 - x0) : '0;
                o_visible <= vis;
                o_last <= lastp;
                o_done_res <= lastp && r_done;
                r_idx <= r_idx + 4'd1;
                if (lastp) r_busy <= 1'b0;
            end
            if (i_job_valid && o_job_ready) begin
                r_busy <= 1'b1;
                r_idx <= '0;
                r_kind <= i_job_kind; r_fill <= i_job_fill;
                r_done <= i_job_done; r_marker <= i_job_marker;
                r_cx <= W'(i_cx); r_cy <= W'(i_cy); r_a <= W'(i_a); r_b <= W'(i_b);
            end
        end
    end
endmodule

@@ tb/tb_top.sv @@
// self-checking testbench for clipped_circle_rasterizer_top: directed table then random circles
// checks every output transfer against an in-bench midpoint circle predictor
// depends on ccr_pkg, ccr_if and the rasterizer rtl
module tb_top import ccr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] center_x;
        logic [15:0] center_y;
        logic [14:0] radius;
    } t_circle_cmd;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [12:0] span_length;
        logic        visible;
        logic        last;
        logic        done_res;
    } t_raster_out;

    typedef struct {
        t_circle_cmd cmd;
        bit          typed;
        t_raster_out res;
    } t_table_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [DIM_BITS-1:0] i_cfg_data;

    ccr_if #(.T(t_circle_cmd)) in_ch ();
    ccr_if #(.T(t_raster_out)) out_ch ();

    clipped_circle_rasterizer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // predictor state
    longint clip_w, clip_h;
    bit     running, filled;
    longint cx, cy, dx, dy, derr;

    t_raster_out pixel_q[$];
    t_table_row  rows[$];
    int          errors;
    int          gap_pct;
    int          stall_pct;
    int          hold_cycles;
    int          sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[clipped_circle_rasterizer_top] ERROR");
        $finish;
    end

    function automatic void put_span(longint x, longint y, longint len);
        t_raster_out r;
        longint x0, x1;
        x0 = (x < 0) ? 0 : x;
        x1 = x + len;
        if (x1 > clip_w) x1 = clip_w;
        r = '0;
        if (y >= 0 && y < clip_h && x1 > x0) begin
            r.pixel_x = x0[11:0];
            r.pixel_y = y[11:0];
            r.span_length = 13'(x1 - x0);
            r.visible = 1'b1;
        end
        pixel_q.push_back(r);
    endfunction

    function automatic void close_item(int base, bit done);
        t_raster_out r;
        if (pixel_q.size() == base) begin
            r = '0;
            pixel_q.push_back(r);
        end
        r = pixel_q[$];
        r.last = 1'b1;
        r.done_res = done;
        pixel_q[pixel_q.size()-1] = r;
        if (done) running = 1'b0;
    endfunction

    function automatic void predict_circle(t_circle_cmd c);
        int     base;
        longint x, y, rad;
        base = pixel_q.size();
        if (c.command == CMD_NONE) return;
        if (c.command != CMD_ADVANCE) begin
            x = longint'(signed'(c.center_x));
            y = longint'(signed'(c.center_y));
            rad = longint'(c.radius);
            running = 1'b0;
            if (x + rad < 0 || y + rad < 0 || x - rad >= clip_w || y - rad >= clip_h) begin
                close_item(base, 1'b1);
                return;
            end
            if (rad == 0) begin
                put_span(x, y, 1);
                close_item(base, 1'b1);
                return;
            end
            filled = (c.command == CMD_FILLED);
            cx = x; cy = y; dx = rad; dy = 0; derr = -rad;
            running = 1'b1;
            if (filled) begin
                put_span(x - rad, y, 2 * rad + 1);
            end else begin
                put_span(x, y - rad, 1);
                put_span(x - rad, y, 1);
                put_span(x + rad, y, 1);
                put_span(x, y + rad, 1);
            end
            close_item(base, 1'b0);
            return;
        end
        if (!running) begin
            close_item(base, 1'b1);
            return;
        end
        derr += 2 * dy + 1;
        dy++;
        if (derr >= 0) begin
            if (filled) begin
                put_span(cx - dy + 1, cy - dx, 2 * dy - 1);
                put_span(cx - dy + 1, cy + dx, 2 * dy - 1);
            end
            derr -= 2 * dx - 1;
            dx--;
        end
        if (dx > dy) begin
            if (filled) begin
                put_span(cx - dx, cy - dy, 2 * dx + 1);
                put_span(cx - dx, cy + dy, 2 * dx + 1);
            end else begin
                put_span(cx - dx, cy - dy, 1);
                put_span(cx + dx, cy - dy, 1);
                put_span(cx - dx, cy + dy, 1);
                put_span(cx + dx, cy + dy, 1);
                put_span(cx - dy, cy - dx, 1);
                put_span(cx - dy, cy + dx, 1);
                put_span(cx + dy, cy - dx, 1);
                put_span(cx + dy, cy + dx, 1);
            end
            close_item(base, 1'b0);
            return;
        end
        if (dx == dy) begin
            if (filled) begin
                put_span(cx - dx, cy - dx, 2 * dx + 1);
                put_span(cx - dx, cy + dx, 2 * dx + 1);
            end else begin
                put_span(cx - dx, cy - dx, 1);
                put_span(cx + dx, cy - dx, 1);
                put_span(cx - dx, cy + dx, 1);
                put_span(cx + dx, cy + dx, 1);
            end
        end
        close_item(base, 1'b1);
    endfunction

    task automatic send_cmd(t_circle_cmd c, bit typed = 1'b0, t_raster_out res = '0);
        int base;
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        base = pixel_q.size();
        predict_circle(c);
        if (typed) begin
            while (pixel_q.size() > base) void'(pixel_q.pop_back());
            pixel_q.push_back(res);
        end
        if (c.command != CMD_NONE) sent++;
    endtask

    task automatic make_cmd(output t_circle_cmd c, input logic [1:0] op, input int x,
                            input int y, input int rad);
        c.command = op;
        c.center_x = x[15:0];
        c.center_y = y[15:0];
        c.radius = rad[14:0];
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        wait (pixel_q.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_frame(int w, int h);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data <= w[DIM_BITS-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data <= h[DIM_BITS-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        clip_w = longint'((w[12:0] > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(w[12:0]));
        clip_h = longint'((h[12:0] > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(h[12:0]));
    endtask

    task automatic add_row(logic [1:0] op, int x, int y, int rad, bit typed = 1'b0,
                           t_raster_out res = '0);
        t_table_row t;
        make_cmd(t.cmd, op, x, y, rad);
        t.typed = typed;
        t.res = res;
        rows.push_back(t);
    endtask

    task automatic random_circle();
        t_circle_cmd c;
        int x, y, rad, steps, pick;
        pick = $urandom_range(99);
        if (pick < 80) begin
            x = int'($urandom_range(32'(clip_w + 40))) - 20;
            y = int'($urandom_range(32'(clip_h + 40))) - 20;
        end else begin
            x = $urandom;
            y = $urandom;
        end
        pick = $urandom_range(99);
        rad = (pick < 70) ? $urandom_range(30) : (pick < 90) ? $urandom_range(200) : $urandom;
        make_cmd(c, $urandom_range(1) ? CMD_FILLED : CMD_OUTLINE, x, y, rad);
        send_cmd(c);
        steps = 0;
        while (running && steps < 60 && $urandom_range(99) != 0) begin
            make_cmd(c, CMD_ADVANCE, $urandom, $urandom, $urandom);
            send_cmd(c);
            steps++;
            if ($urandom_range(99) < 3) begin
                make_cmd(c, CMD_NONE, $urandom, $urandom, $urandom);
                send_cmd(c);
            end
        end
        if ($urandom_range(99) < 10) begin
            make_cmd(c, CMD_ADVANCE, 0, 0, 0);
            send_cmd(c);
        end
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // output checker
    always @(posedge i_clk) begin
        t_raster_out e, a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected transfer, actual %p", $time, a);
                errors++;
            end else begin
                e = pixel_q.pop_front();
                if (a.pixel_x !== e.pixel_x || a.pixel_y !== e.pixel_y
                        || a.span_length !== e.span_length || a.visible !== e.visible
                        || a.last !== e.last || a.done_res !== e.done_res) begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, e, a);
                    errors++;
                end
            end
        end
    end

    initial begin
        int frame_w[7] = '{4096, 640, 1, 8191, 0, 37, 4096};
        int frame_h[7] = '{4096, 480, 1, 8191, 5, 4096, 13};
        int idle_gap[4] = '{0, 74, 0, 32};
        int idle_stall[4] = '{0, 0, 74, 32};
        int target;
        errors = 0;
        sent = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        clip_w = MAX_DIM_DEF;
        clip_h = MAX_DIM_DEF;
        running = 1'b0;
        filled = 1'b0;
        cx = 0; cy = 0; dx = 0; dy = 0; derr = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        add_row(CMD_ADVANCE, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 1, 1});
        add_row(CMD_OUTLINE, 5, 7, 0, 1'b1, '{5, 7, 1, 1, 1, 1});
        add_row(CMD_FILLED, -100, -100, 10, 1'b1, '{0, 0, 0, 0, 1, 1});
        add_row(CMD_OUTLINE, 32767, -32768, 32767, 1'b1, '{0, 0, 0, 0, 1, 1});
        add_row(CMD_FILLED, -32768, 32767, 32767, 1'b1, '{0, 0, 0, 0, 1, 1});
        add_row(CMD_OUTLINE, 100, 100, 5);
        repeat (6) add_row(CMD_ADVANCE, 0, 0, 0);
        add_row(CMD_FILLED, 2, 4090, 4);
        repeat (3) add_row(CMD_ADVANCE, -1, -1, 32767);
        add_row(CMD_NONE, -1, -1, 32767);
        add_row(CMD_ADVANCE, 0, 0, 0);
        add_row(CMD_OUTLINE, 4095, 0, 3);
        add_row(CMD_FILLED, 0, 0, 32767);
        add_row(CMD_ADVANCE, 0, 0, 0);
        add_row(CMD_OUTLINE, 0, 0, 32767);
        add_row(CMD_ADVANCE, 0, 0, 0);
        foreach (rows[k]) send_cmd(rows[k].cmd, rows[k].typed, rows[k].res);
        drain();

        for (int p = 0; p < 7; p++) begin
            if (p > 0 || $urandom_range(1)) write_frame(frame_w[p], frame_h[p]);
            gap_pct = idle_gap[p % 4];
            stall_pct = idle_stall[p % 4];
            if (p == 2) hold_cycles = 300;
            target = sent + 60;
            while (sent < target) random_circle();
            drain();
        end

        wait (pixel_q.size() == 0);
        repeat (30) @(posedge i_clk);
        if (errors == 0 && pixel_q.size() == 0) begin
            $display("[clipped_circle_rasterizer_top] OK");
        end else begin
            $display("[clipped_circle_rasterizer_top] ERROR");
        end
        $finish;
    end
endmodule
